// File: rtl/core/vcrv_pkg.sv
// Shared types and constants of the video register and memory port.
// Used by every module in rtl/core but vcrv_ram; depends on nothing.
package vcrv_pkg;

    localparam int DATA_W = 8;
    localparam int ADDR_W = 16;
    localparam int MEM_DEPTH = 65536;
    localparam int INSTALLED_BYTES_DEFAULT = 65536;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_REG_READ = 2'd0;
    localparam logic [1:0] OP_REG_WRITE = 2'd1;
    localparam logic [1:0] OP_MEM_READ = 2'd2;
    localparam logic [1:0] OP_MEM_WRITE = 2'd3;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } cmd_t;

endpackage

// File: rtl/core/vcrv_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module vcrv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/vcrv_queue.sv
// Short command queue between the front end and the memory back end.
// Depends on vcrv_pkg for the command type.
module vcrv_queue #(
    parameter int DEPTH = vcrv_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  vcrv_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output vcrv_pkg::cmd_t pop_cmd,
    output logic           nonempty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vcrv_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_cmd  = mem_reg[rd_ptr_reg];

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != CW'(DEPTH))
        else $error("queue pushed while full");

endmodule

// File: rtl/core/vcrv_front.sv
// Front end: accepts bus accesses, runs the register sequence and address pointers,
// and queues one command per access. Depends on vcrv_pkg.
module vcrv_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [vcrv_pkg::DATA_W-1:0]   s_write_data,
    input  logic                          mem_ready,
    input  logic                          q_full,
    output logic                          q_push,
    output vcrv_pkg::cmd_t                q_cmd
);

    localparam logic [1:0] PH_SELECT = 2'd0;
    localparam logic [1:0] PH_VALUE  = 2'd1;
    localparam logic [1:0] PH_HIGH   = 2'd2;
    localparam logic [1:0] PH_TAIL   = 2'd3;

    localparam logic [3:0] SEL_CTRL_HI = 4'd2;
    localparam logic [3:0] SEL_DIRECT  = 4'd9;
    localparam logic [3:0] SEL_REG10   = 4'd10;
    localparam logic [3:0] SEL_REG15   = 4'd15;
    localparam logic [2:0] CTRL_LO     = 3'd1;
    localparam logic [2:0] CTRL_HI     = 3'd2;
    localparam logic [2:0] ADDR_RD     = 3'd1;

    localparam int AW = vcrv_pkg::ADDR_W;
    localparam int DW = vcrv_pkg::DATA_W;

    logic [DW-1:0] ctrl_reg [8];
    logic [DW-1:0] ctrl_next [8];
    logic [AW-1:0] addr_reg [8];
    logic [AW-1:0] addr_next [8];
    logic [AW-1:0] wp_reg, wp_next;
    logic [3:0]    sel_reg, sel_next;
    logic [1:0]    phase_reg, phase_next;
    logic          pend_reg, pend_next;

    logic [2:0]    ai;
    logic [1:0]    ph;
    logic [AW-1:0] pair;
    logic [AW-1:0] hi_val;
    logic [AW-1:0] wp_use;

    assign s_ready = mem_ready && !q_full;
    assign q_push  = s_valid && s_ready;

    assign ai     = sel_reg[2:0];
    assign pair   = {ctrl_reg[CTRL_HI], ctrl_reg[CTRL_LO]};
    assign hi_val = {ctrl_reg[CTRL_HI], addr_reg[ai][7:0]};
    assign wp_use = pend_reg ? pair : wp_reg;
    assign ph     = (phase_reg == PH_TAIL && s_write_data != '0) ? PH_SELECT : phase_reg;

    always_comb begin
        ctrl_next  = ctrl_reg;
        addr_next  = addr_reg;
        wp_next    = wp_reg;
        sel_next   = sel_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        q_cmd      = '{kind: vcrv_pkg::KIND_REPLY, addr: '0, data: '0};
        if (q_push) begin
            case (s_operation)
                vcrv_pkg::OP_REG_READ: begin
                    if (!sel_reg[3]) begin
                        q_cmd.data = ctrl_reg[ai];
                        phase_next = PH_SELECT;
                    end
                end
                vcrv_pkg::OP_REG_WRITE: begin
                    case (ph)
                        PH_SELECT: begin
                            sel_next   = s_write_data[3:0];
                            phase_next = PH_VALUE;
                        end
                        PH_VALUE: begin
                            if (!sel_reg[3]) begin
                                ctrl_next[ai] = s_write_data;
                                phase_next    = PH_SELECT;
                                if (sel_reg == SEL_CTRL_HI) begin
                                    pend_next = 1'b1;
                                end
                            end else if (sel_reg == SEL_DIRECT) begin
                                addr_next[ADDR_RD] = pair + 1'b1;
                                phase_next         = PH_SELECT;
                                pend_next          = 1'b0;
                            end else begin
                                addr_next[ai] = {addr_reg[ai][15:8], ctrl_reg[CTRL_LO]};
                                phase_next    = PH_HIGH;
                                pend_next     = 1'b0;
                            end
                        end
                        PH_HIGH: begin
                            if (sel_reg <= SEL_REG10 || sel_reg == SEL_REG15) begin
                                addr_next[ai] = hi_val + AW'(1);
                            end else begin
                                addr_next[ai] = hi_val + AW'(2);
                            end
                            phase_next = PH_TAIL;
                        end
                        default: begin
                            phase_next = PH_SELECT;
                        end
                    endcase
                end
                vcrv_pkg::OP_MEM_READ: begin
                    if (pend_reg) begin
                        wp_next   = pair + 1'b1;
                        pend_next = 1'b0;
                    end
                    q_cmd.kind         = vcrv_pkg::KIND_READ;
                    q_cmd.addr         = addr_reg[ADDR_RD];
                    addr_next[ADDR_RD] = addr_reg[ADDR_RD] + 1'b1;
                end
                default: begin
                    pend_next  = 1'b0;
                    q_cmd.kind = vcrv_pkg::KIND_WRITE;
                    q_cmd.addr = wp_use;
                    q_cmd.data = s_write_data;
                    wp_next    = wp_use + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                ctrl_reg[i] <= '0;
                addr_reg[i] <= '0;
            end
            wp_reg    <= '0;
            sel_reg   <= '0;
            phase_reg <= PH_SELECT;
            pend_reg  <= 1'b0;
        end else begin
            ctrl_reg  <= ctrl_next;
            addr_reg  <= addr_next;
            wp_reg    <= wp_next;
            sel_reg   <= sel_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// File: rtl/core/vcrv_back.sv
// Back end: fills video memory after reset, carries out queued commands,
// and holds the result register. Depends on vcrv_pkg and vcrv_ram.
module vcrv_back #(
    parameter int INSTALLED_BYTES = vcrv_pkg::INSTALLED_BYTES_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_nonempty,
    input  vcrv_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output logic                        mem_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vcrv_pkg::DATA_W-1:0] m_read_data
);

    localparam int AW = vcrv_pkg::ADDR_W;
    localparam int DW = vcrv_pkg::DATA_W;
    localparam logic [AW:0] INSTALLED_LIM = (AW + 1)'(INSTALLED_BYTES);

    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          inflight_reg, inflight_next;
    logic          m_valid_reg, m_valid_next;
    logic [DW-1:0] m_data_reg, m_data_next;

    logic          ram_en;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [DW-1:0] ram_wdata;
    logic [DW-1:0] ram_rdata;
    logic [DW-1:0] clr_value;

    assign q_pop = !clearing_reg && q_nonempty && !inflight_reg && (!m_valid_reg || m_ready);
    assign mem_ready = !clearing_reg;
    assign clr_value = ({1'b0, clr_addr_reg} < INSTALLED_LIM) ? '0 : '1;

    always_comb begin
        ram_en    = clearing_reg || q_pop;
        ram_we    = clearing_reg || (q_pop && q_cmd.kind == vcrv_pkg::KIND_WRITE);
        ram_addr  = clearing_reg ? clr_addr_reg : q_cmd.addr;
        ram_wdata = clearing_reg ? clr_value : q_cmd.data;
    end

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1) begin
                clearing_next = 1'b0;
            end
        end
        inflight_next = q_pop && q_cmd.kind == vcrv_pkg::KIND_READ;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        if (inflight_reg) begin
            m_valid_next = 1'b1;
            m_data_next  = ram_rdata;
        end else if (q_pop && q_cmd.kind != vcrv_pkg::KIND_READ) begin
            m_valid_next = 1'b1;
            m_data_next  = (q_cmd.kind == vcrv_pkg::KIND_REPLY) ? q_cmd.data : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            inflight_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            inflight_reg <= inflight_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    vcrv_ram #(
        .WIDTH (DW),
        .DEPTH (vcrv_pkg::MEM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;

    a_inflight_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg |-> !m_valid_reg)
        else $error("memory read in flight while the result register is full");

    a_inflight_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg |=> m_valid_reg)
        else $error("memory read did not reach the result register");

    a_no_pop_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !q_pop && !inflight_reg)
        else $error("command carried out during the clearing pass");

endmodule

// File: rtl/core/video_chip_register_vram_port.sv
// Top level of the video register and memory port.
// Depends on vcrv_pkg, vcrv_front, vcrv_queue and vcrv_back.
//
// After reset the block sweeps the whole 64 KiB video memory, one byte per cycle, writing
// zero below INSTALLED_BYTES and 0xff from there up; s_ready stays low during the sweep.
// Then the front end takes one access per cycle while its queue (two entries by default) has
// room, and decides all register and pointer effects at once. The back end owns the single
// RAM port: register accesses and memory writes go straight to the result register and flow
// one item per cycle while the sink takes results; a memory read first passes the registered
// RAM read data, and no new item is taken while it is in flight. Results leave in arrival order.
module video_chip_register_vram_port #(
    parameter int INSTALLED_BYTES = vcrv_pkg::INSTALLED_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH = vcrv_pkg::QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_operation,
    input  logic [vcrv_pkg::DATA_W-1:0] s_write_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vcrv_pkg::DATA_W-1:0] m_read_data
);

    logic           mem_ready;
    logic           q_full;
    logic           q_push;
    vcrv_pkg::cmd_t q_push_cmd;
    logic           q_pop;
    vcrv_pkg::cmd_t q_pop_cmd;
    logic           q_nonempty;

    vcrv_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_write_data (s_write_data),
        .mem_ready    (mem_ready),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_push_cmd)
    );

    vcrv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .nonempty (q_nonempty)
    );

    vcrv_back #(
        .INSTALLED_BYTES (INSTALLED_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_nonempty  (q_nonempty),
        .q_cmd       (q_pop_cmd),
        .q_pop       (q_pop),
        .mem_ready   (mem_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data)
    );

endmodule

// File: dv/vram_port_shadow_pkg.sv
// Shadow copy of the video register and memory port: a cycle-free predictor of every access
// plus the queue of reply bytes still due from the block. Depends on vcrv_pkg from the RTL.
package vram_port_shadow_pkg;
    import vcrv_pkg::*;

    typedef enum logic [1:0] {
        PH_SELECT,
        PH_VALUE,
        PH_HIGH_BYTE,
        PH_TRAILER
    } access_phase_e;

    localparam logic [3:0] REG_PTR_LOW = 4'd1;
    localparam logic [3:0] REG_PTR_HIGH = 4'd2;
    localparam logic [3:0] REG_FIRST_ADDR = 4'd8;
    localparam logic [3:0] REG_READ_ADDR = 4'd9;
    localparam logic [3:0] REG_LAST_STEP_ONE = 4'd10;
    localparam logic [3:0] REG_LAST = 4'd15;
    localparam logic [2:0] READ_ADDR_SLOT = 3'd1;
    localparam int REPORT_LINES_MAX = 40;

    class vram_port_shadow;
        logic [7:0]    ctrl_regs [8];
        logic [15:0]   addr_regs [8];
        logic [15:0]   write_ptr;
        logic [3:0]    selected;
        access_phase_e phase;
        bit            reload_pending;
        logic [7:0]    vram [MEM_DEPTH];
        logic [7:0]    reply_bytes_due [$];
        int            mismatch_count;

        function new();
            foreach (ctrl_regs[i]) begin
                ctrl_regs[i] = 8'h00;
                addr_regs[i] = 16'h0000;
            end
            write_ptr = 16'h0000;
            selected = 4'h0;
            phase = PH_SELECT;
            reload_pending = 1'b0;
            mismatch_count = 0;
            for (int a = 0; a < MEM_DEPTH; a++) begin
                vram[a] = (a < INSTALLED_BYTES_DEFAULT) ? 8'h00 : 8'hff;
            end
        endfunction

        function void register_write(logic [7:0] data);
            logic [3:0]  sel;
            logic [2:0]  slot;
            logic [15:0] pair;
            sel = selected;
            slot = sel[2:0];
            pair = {ctrl_regs[REG_PTR_HIGH], ctrl_regs[REG_PTR_LOW]};
            // A nonzero byte after an address load starts a new register select.
            if (phase == PH_TRAILER && data != 8'h00) begin
                phase = PH_SELECT;
            end
            case (phase)
                PH_SELECT: begin
                    selected = data[3:0];
                    phase = PH_VALUE;
                end
                PH_VALUE: begin
                    if (sel < REG_FIRST_ADDR) begin
                        ctrl_regs[slot] = data;
                        phase = PH_SELECT;
                        if (sel == REG_PTR_HIGH) begin
                            reload_pending = 1'b1;
                        end
                    end else if (sel == REG_READ_ADDR) begin
                        addr_regs[READ_ADDR_SLOT] = pair + 16'd1;
                        phase = PH_SELECT;
                        reload_pending = 1'b0;
                    end else begin
                        addr_regs[slot][7:0] = ctrl_regs[REG_PTR_LOW];
                        phase = PH_HIGH_BYTE;
                        reload_pending = 1'b0;
                    end
                end
                PH_HIGH_BYTE: begin
                    addr_regs[slot][15:8] = ctrl_regs[REG_PTR_HIGH];
                    if (sel <= REG_LAST_STEP_ONE || sel == REG_LAST) begin
                        addr_regs[slot] = addr_regs[slot] + 16'd1;
                    end else begin
                        addr_regs[slot] = addr_regs[slot] + 16'd2;
                    end
                    phase = PH_TRAILER;
                end
                default: begin
                    phase = PH_SELECT;
                end
            endcase
        endfunction

        function logic [7:0] apply_access(logic [1:0] op, logic [7:0] data);
            logic [7:0]  reply;
            logic [15:0] pair;
            reply = 8'h00;
            pair = {ctrl_regs[REG_PTR_HIGH], ctrl_regs[REG_PTR_LOW]};
            case (op)
                OP_REG_READ: begin
                    if (selected < REG_FIRST_ADDR) begin
                        reply = ctrl_regs[selected[2:0]];
                        phase = PH_SELECT;
                    end
                end
                OP_REG_WRITE: begin
                    register_write(data);
                end
                OP_MEM_READ: begin
                    if (reload_pending) begin
                        write_ptr = pair + 16'd1;
                        reload_pending = 1'b0;
                    end
                    reply = vram[addr_regs[READ_ADDR_SLOT]];
                    addr_regs[READ_ADDR_SLOT] = addr_regs[READ_ADDR_SLOT] + 16'd1;
                end
                default: begin
                    if (reload_pending) begin
                        write_ptr = pair;
                        reload_pending = 1'b0;
                    end
                    vram[write_ptr] = data;
                    write_ptr = write_ptr + 16'd1;
                end
            endcase
            return reply;
        endfunction

        function void note_access(logic [1:0] op, logic [7:0] data);
            reply_bytes_due.push_back(apply_access(op, data));
        endfunction

        function int outstanding();
            return reply_bytes_due.size();
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            if (mismatch_count <= REPORT_LINES_MAX) begin
                $display("MISMATCH: %s", what);
            end
        endtask

        task check_read(logic [7:0] got);
            logic [7:0] want;
            if (reply_bytes_due.size() == 0) begin
                report_mismatch($sformatf("read_data 0x%02h with no access outstanding", got));
            end else begin
                want = reply_bytes_due.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("read_data 0x%02h, predicted 0x%02h", got, want));
                end
            end
        endtask
    endclass

endpackage

// File: dv/testbench.sv
// Top-level testbench of video_chip_register_vram_port: drives register and video memory
// accesses with random gaps and stalls, and checks every reply byte against the shadow model.
// Depends on vcrv_pkg, vram_port_shadow_pkg and the RTL under rtl/core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vcrv_pkg::*;
    import vram_port_shadow_pkg::*;

    localparam int ITEM_TARGET = 1600;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 10;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_operation;
    logic [DATA_W-1:0]        s_write_data;
    logic                     m_valid;
    logic                     m_ready;
    logic [DATA_W-1:0]        m_read_data;

    int              sender_idle_pct = 0;
    int              sink_stall_pct = 0;
    bit              long_hold_req = 1'b0;
    int              items_sent = 0;
    vram_port_shadow shadow;

    video_chip_register_vram_port DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_write_data(s_write_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data)
    );

    always #5 aclk = ~aclk;

    task automatic send_access(input logic [1:0] op, input logic [7:0] data);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        shadow.note_access(op, data);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (shadow.outstanding() != 0);
    endtask

    task automatic settle_phase();
        while (shadow.phase != PH_SELECT) begin
            send_access(OP_REG_WRITE, 8'h00);
        end
    endtask

    task automatic select_register(input logic [3:0] reg_index);
        send_access(OP_REG_WRITE, {4'($urandom_range(15)), reg_index});
    endtask

    task automatic set_control(input logic [3:0] reg_index, input logic [7:0] value);
        settle_phase();
        select_register(reg_index);
        send_access(OP_REG_WRITE, value);
    endtask

    task automatic load_read_address();
        settle_phase();
        select_register(REG_READ_ADDR);
        send_access(OP_REG_WRITE, 8'($urandom));
    endtask

    function automatic logic [15:0] pick_base();
        case ($urandom_range(4))
            0: return 16'h0000;
            1: return 16'hfff8 + 16'($urandom_range(7));
            2: return 16'h3c00 + 16'($urandom_range(15));
            3: return 16'($urandom_range(63));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_directed();
        send_access(OP_REG_READ, 8'hff);
        set_control(REG_PTR_LOW, 8'hff);
        set_control(REG_PTR_HIGH, 8'hff);
        // The pending reload points the write pointer at the top byte, so the second
        // write wraps to address zero.
        send_access(OP_MEM_WRITE, 8'ha5);
        send_access(OP_MEM_WRITE, 8'h5a);
        set_control(REG_PTR_LOW, 8'hfe);
        send_access(OP_REG_WRITE, {4'hf, REG_READ_ADDR});
        send_access(OP_REG_WRITE, 8'h00);
        send_access(OP_MEM_READ, 8'h00);
        send_access(OP_MEM_READ, 8'hff);
        send_access(OP_REG_WRITE, 8'h0b);
        send_access(OP_REG_WRITE, 8'h33);
        send_access(OP_REG_WRITE, 8'h44);
        send_access(OP_REG_WRITE, 8'h00);
        send_access(OP_REG_READ, 8'h00);
        send_access(OP_REG_WRITE, {4'h0, REG_LAST});
        send_access(OP_REG_WRITE, 8'h01);
        send_access(OP_REG_WRITE, 8'h02);
        send_access(OP_REG_WRITE, 8'h07);
        send_access(OP_REG_WRITE, 8'h80);
        send_access(OP_REG_READ, 8'h00);
        set_control(REG_PTR_HIGH, 8'h12);
        send_access(OP_MEM_READ, 8'h00);
        send_access(OP_MEM_WRITE, 8'hc3);
    endtask

    task automatic random_sequence();
        int          kind;
        int          count;
        logic [15:0] base;
        kind = $urandom_range(99);
        count = $urandom_range(1, 8);
        base = pick_base();
        if (kind < 20) begin
            set_control(4'($urandom_range(7)), 8'($urandom));
        end else if (kind < 45) begin
            set_control(REG_PTR_LOW, base[7:0]);
            set_control(REG_PTR_HIGH, base[15:8]);
            repeat (count) send_access(OP_MEM_WRITE, 8'($urandom));
            if ($urandom_range(1) == 1) begin
                load_read_address();
                repeat (count) send_access(OP_MEM_READ, 8'($urandom));
            end
        end else if (kind < 60) begin
            if ($urandom_range(1) == 1) begin
                set_control(REG_PTR_LOW, base[7:0]);
                set_control(REG_PTR_HIGH, base[15:8]);
            end
            load_read_address();
            repeat (count) send_access(OP_MEM_READ, 8'($urandom));
        end else if (kind < 72) begin
            settle_phase();
            select_register(4'($urandom_range(REG_FIRST_ADDR, REG_LAST)));
            send_access(OP_REG_WRITE, 8'($urandom));
            send_access(OP_REG_WRITE, 8'($urandom));
            send_access(OP_REG_WRITE,
                        ($urandom_range(1) == 1) ? 8'h00 : 8'($urandom_range(1, 255)));
        end else if (kind < 85) begin
            settle_phase();
            select_register(4'($urandom_range(15)));
            repeat ($urandom_range(1, 3)) send_access(OP_REG_READ, 8'($urandom));
        end else begin
            repeat (count) send_access(2'($urandom_range(3)), 8'($urandom));
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                long_hold_req = 1'b0;
            end
            m_ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            shadow.check_read(m_read_data);
        end
    end

    initial begin
        int stage;
        int last_stage;
        int waited;
        shadow = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_REG_READ;
        s_write_data = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        run_directed();
        last_stage = -1;
        while (items_sent < ITEM_TARGET) begin
            stage = (items_sent * 4) / ITEM_TARGET;
            if (stage != last_stage) begin
                pause_until_drained();
                case (stage)
                    0: begin
                        sender_idle_pct = 0;
                        sink_stall_pct = 0;
                    end
                    1: begin
                        sender_idle_pct = 57;
                        sink_stall_pct = 0;
                    end
                    2: begin
                        sender_idle_pct = 0;
                        sink_stall_pct = 57;
                    end
                    default: begin
                        sender_idle_pct = 32;
                        sink_stall_pct = 32;
                    end
                endcase
                if (stage == 0 || stage == 3) begin
                    long_hold_req = 1'b1;
                end
                last_stage = stage;
            end
            random_sequence();
        end
        s_valid <= 1'b0;
        waited = 0;
        while (shadow.outstanding() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (shadow.outstanding() != 0) begin
            shadow.report_mismatch($sformatf("%0d replies never arrived",
                                             shadow.outstanding()));
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (shadow.mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
